>>> rtl/asm_comment_stripper_defines.svh
// ----------------------------------------------------------------------------
// asm comment stripper assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef ASM_COMMENT_STRIPPER_DEFINES_SVH
`define ASM_COMMENT_STRIPPER_DEFINES_SVH

// same-cycle implication, off during reset
`define ACS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("asm_comment_stripper: implication check failed");

// next-cycle implication, off during reset
`define ACS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("asm_comment_stripper: next-cycle check failed");

// state right after a reset cycle
`define ACS_ASSERT_AFTER_RESET(lbl, clk, rstn, cons) \
    lbl: assert property (@(posedge clk) !(rstn) |=> (cons)) \
        else $error("asm_comment_stripper: reset check failed");

`endif

>>> rtl/asm_cs_pkg.sv
// ----------------------------------------------------------------------------
// asm comment stripper package
// character codes, queue depth and the request passed from front to back
// ----------------------------------------------------------------------------
package asm_cs_pkg;

    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;

    localparam int QUEUE_DEPTH = 2;

    // up to three result bytes made by one source byte
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      last_idx;
        logic            has_end;
    } req_t;

endpackage

>>> rtl/asm_comment_stripper.sv
// ----------------------------------------------------------------------------
// asm comment stripper
// removes block and line comments from assembler source, one byte per request
// ----------------------------------------------------------------------------
// A source byte is taken in every cycle while the request queue has room.
// Each byte gives zero to three result bytes; the output port sends one
// result per cycle while m_ready is high, so bytes with one result or none
// stream at one per clock and a byte with more holds the output until all
// are sent. The queue between classifier and output sequencer (QUEUE_DEPTH
// entries) absorbs the bursts; results pass it, then the output register.
// end_of_input flushes a held slash, adds an end marker (zero byte with
// m_is_end_marker set) and returns the comment and string state to reset.
module asm_comment_stripper #(
    parameter int QUEUE_DEPTH = asm_cs_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_input,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_is_end_marker,
    output logic       m_last_of_run
);

    logic             fr_valid;
    logic             fr_ready;
    asm_cs_pkg::req_t fr_req;
    logic             bk_valid;
    logic             bk_pop;
    asm_cs_pkg::req_t bk_req;

    asm_cs_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_end_of_input (s_end_of_input),
        .req_valid      (fr_valid),
        .req_ready      (fr_ready),
        .req            (fr_req)
    );

    asm_cs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_req   (fr_req),
        .rd_valid (bk_valid),
        .rd_pop   (bk_pop),
        .rd_req   (bk_req)
    );

    asm_cs_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .req_valid       (bk_valid),
        .req_pop         (bk_pop),
        .req             (bk_req),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_is_end_marker (m_is_end_marker),
        .m_last_of_run   (m_last_of_run)
    );

endmodule

>>> rtl/asm_cs_front.sv
// ----------------------------------------------------------------------------
// asm comment stripper front end
// classifies each source byte, tracks comment and string state, builds a request
// ----------------------------------------------------------------------------
module asm_cs_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_in_byte,
    input  logic             s_end_of_input,
    output logic             req_valid,
    input  logic             req_ready,
    output asm_cs_pkg::req_t req
);

    logic block_comment_reg,   block_comment_next;
    logic star_seen_reg,       star_seen_next;
    logic slash_held_reg,      slash_held_next;
    logic in_quote_reg,        in_quote_next;
    logic quote_single_reg,    quote_single_next;
    logic escape_pending_reg,  escape_pending_next;
    logic skip_line_reg,       skip_line_next;

    logic            accept;
    logic [1:0]      n;
    logic [2:0][7:0] data;
    logic            has_end;
    logic            do_plain;
    logic [7:0]      c;
    logic [7:0]      quote_char;

    assign c       = s_in_byte;
    assign s_ready = req_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        block_comment_next  = block_comment_reg;
        star_seen_next      = star_seen_reg;
        slash_held_next     = slash_held_reg;
        in_quote_next       = in_quote_reg;
        quote_single_next   = quote_single_reg;
        escape_pending_next = escape_pending_reg;
        skip_line_next      = skip_line_reg;
        n          = 2'd0;
        data       = '0;
        has_end    = 1'b0;
        do_plain   = 1'b0;
        quote_char = quote_single_reg ? asm_cs_pkg::CHAR_SQUOTE : asm_cs_pkg::CHAR_DQUOTE;

        if (c == asm_cs_pkg::CHAR_NL) begin
            if (slash_held_reg) begin
                data[n] = asm_cs_pkg::CHAR_SLASH;
                n = n + 2'd1;
                slash_held_next = 1'b0;
            end
            data[n] = asm_cs_pkg::CHAR_NL;
            n = n + 2'd1;
            in_quote_next       = 1'b0;
            quote_single_next   = 1'b0;
            escape_pending_next = 1'b0;
            skip_line_next      = 1'b0;
            star_seen_next      = 1'b0;
        end else if (block_comment_reg) begin
            if (star_seen_reg && c == asm_cs_pkg::CHAR_SLASH) begin
                block_comment_next = 1'b0;
                star_seen_next     = 1'b0;
            end else begin
                star_seen_next = (c == asm_cs_pkg::CHAR_STAR);
            end
        end else if (skip_line_reg) begin
            skip_line_next = 1'b1;
        end else if (in_quote_reg) begin
            data[n] = c;
            n = n + 2'd1;
            if (escape_pending_reg) begin
                escape_pending_next = 1'b0;
            end else if (c == asm_cs_pkg::CHAR_BSLASH) begin
                escape_pending_next = 1'b1;
            end else if (c == quote_char) begin
                in_quote_next     = 1'b0;
                quote_single_next = 1'b0;
            end
        end else if (slash_held_reg) begin
            slash_held_next = 1'b0;
            if (c == asm_cs_pkg::CHAR_STAR) begin
                block_comment_next = 1'b1;
                star_seen_next     = 1'b0;
            end else if (c == asm_cs_pkg::CHAR_SLASH) begin
                skip_line_next = 1'b1;
            end else begin
                data[n] = asm_cs_pkg::CHAR_SLASH;
                n = n + 2'd1;
                do_plain = 1'b1;
            end
        end else begin
            do_plain = 1'b1;
        end

        if (do_plain) begin
            if (c == asm_cs_pkg::CHAR_DQUOTE || c == asm_cs_pkg::CHAR_SQUOTE) begin
                in_quote_next       = 1'b1;
                quote_single_next   = (c == asm_cs_pkg::CHAR_SQUOTE);
                escape_pending_next = 1'b0;
                data[n] = c;
                n = n + 2'd1;
            end else if (c == asm_cs_pkg::CHAR_SLASH) begin
                slash_held_next = 1'b1;
            end else if (c == asm_cs_pkg::CHAR_HASH || c == asm_cs_pkg::CHAR_SEMI) begin
                skip_line_next = 1'b1;
            end else begin
                data[n] = c;
                n = n + 2'd1;
            end
        end

        if (s_end_of_input) begin
            if (slash_held_next) begin
                data[n] = asm_cs_pkg::CHAR_SLASH;
                n = n + 2'd1;
            end
            // end marker: zero byte in the last slot
            n = n + 2'd1;
            has_end = 1'b1;
            block_comment_next  = 1'b0;
            star_seen_next      = 1'b0;
            slash_held_next     = 1'b0;
            in_quote_next       = 1'b0;
            quote_single_next   = 1'b0;
            escape_pending_next = 1'b0;
            skip_line_next      = 1'b0;
        end
    end

    assign req_valid    = s_valid && (n != 2'd0);
    assign req.data     = data;
    assign req.last_idx = n - 2'd1;
    assign req.has_end  = has_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_comment_reg  <= 1'b0;
            star_seen_reg      <= 1'b0;
            slash_held_reg     <= 1'b0;
            in_quote_reg       <= 1'b0;
            quote_single_reg   <= 1'b0;
            escape_pending_reg <= 1'b0;
            skip_line_reg      <= 1'b0;
        end else if (accept) begin
            block_comment_reg  <= block_comment_next;
            star_seen_reg      <= star_seen_next;
            slash_held_reg     <= slash_held_next;
            in_quote_reg       <= in_quote_next;
            quote_single_reg   <= quote_single_next;
            escape_pending_reg <= escape_pending_next;
            skip_line_reg      <= skip_line_next;
        end
    end

endmodule

>>> rtl/asm_cs_queue.sv
// ----------------------------------------------------------------------------
// asm comment stripper request queue
// small register queue decoupling the front end from the output sequencer
// ----------------------------------------------------------------------------
module asm_cs_queue #(
    parameter int DEPTH = asm_cs_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  asm_cs_pkg::req_t wr_req,
    output logic             rd_valid,
    input  logic             rd_pop,
    output asm_cs_pkg::req_t rd_req
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    asm_cs_pkg::req_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_req   = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/asm_cs_back.sv
// ----------------------------------------------------------------------------
// asm comment stripper output sequencer
// walks the slots of the head request and drives one result per cycle while m_ready is high
// ----------------------------------------------------------------------------
module asm_cs_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             req_valid,
    output logic             req_pop,
    input  asm_cs_pkg::req_t req,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_is_end_marker,
    output logic             m_last_of_run
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       end_reg;
    logic       last_reg;
    logic       load;
    logic       at_last;

    assign load    = req_valid && (!valid_reg || m_ready);
    assign at_last = (idx_reg == req.last_idx);
    assign req_pop = load && at_last;
    assign idx_next = at_last ? 2'd0 : idx_reg + 2'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= idx_next;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= req.data[idx_reg];
            end_reg  <= at_last && req.has_end;
            last_reg <= at_last;
        end
    end

    assign m_valid         = valid_reg;
    assign m_out_byte      = byte_reg;
    assign m_is_end_marker = end_reg;
    assign m_last_of_run   = last_reg;

endmodule

>>> rtl/asm_cs_checker.sv
// ----------------------------------------------------------------------------
// asm comment stripper port checker
// checks result channel behavior seen at the top level ports
// ----------------------------------------------------------------------------
`include "asm_comment_stripper_defines.svh"

module asm_cs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_is_end_marker,
    input logic       m_last_of_run
);

    `ACS_ASSERT_AFTER_RESET(a_idle_after_reset, aclk, aresetn, !m_valid)

    `ACS_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_byte) && $stable(m_is_end_marker) && $stable(m_last_of_run))

    `ACS_ASSERT_IMPLY(a_end_is_last, aclk, aresetn, m_valid && m_is_end_marker, m_last_of_run)

    `ACS_ASSERT_IMPLY(a_end_byte_zero, aclk, aresetn, m_valid && m_is_end_marker, m_out_byte == 8'h00)

endmodule

bind asm_comment_stripper asm_cs_checker u_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_out_byte      (m_out_byte),
    .m_is_end_marker (m_is_end_marker),
    .m_last_of_run   (m_last_of_run)
);

>>> test/asm_comment_stripper_test.sv
// ----------------------------------------------------------------------------
// asm comment stripper testbench
// A short table of source bytes covers the byte extremes, every comment and
// string form and the end-of-input flush. Random assembler-like text follows
// in four handshake phases. A behavioral copy of the stripper predicts the
// results of rows not pinned to typed bytes; all are checked in order.
// ----------------------------------------------------------------------------
module asm_comment_stripper_test;

    localparam logic [7:0] CHAR_NL     = asm_cs_pkg::CHAR_NL;
    localparam logic [7:0] CHAR_STAR   = asm_cs_pkg::CHAR_STAR;
    localparam logic [7:0] CHAR_SLASH  = asm_cs_pkg::CHAR_SLASH;
    localparam logic [7:0] CHAR_HASH   = asm_cs_pkg::CHAR_HASH;
    localparam logic [7:0] CHAR_SEMI   = asm_cs_pkg::CHAR_SEMI;
    localparam logic [7:0] CHAR_DQUOTE = asm_cs_pkg::CHAR_DQUOTE;
    localparam logic [7:0] CHAR_SQUOTE = asm_cs_pkg::CHAR_SQUOTE;
    localparam logic [7:0] CHAR_BSLASH = asm_cs_pkg::CHAR_BSLASH;

    typedef struct packed {
        logic [7:0] data;
        logic       endm;
        logic       last;
    } strip_out_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
        logic       pinned;
        logic [1:0] cnt;
        logic [7:0] w0;
        logic [7:0] w1;
        logic [7:0] w2;
    } stim_row_t;

    localparam logic PRED = 1'b0;
    localparam logic PIN = 1'b1;
    localparam logic [7:0] END_BYTE = 8'h00;
    localparam int NUM_DIR = 32;
    localparam int NUM_RAND = 120;

    // typed results only where they are obvious, the rest come from the predictor
    localparam stim_row_t DIR_ROWS [NUM_DIR] = '{
        '{8'h61,       1'b0, PIN,  2'd1, 8'h61,      8'h00,   8'h00},
        '{8'h00,       1'b0, PIN,  2'd1, 8'h00,      8'h00,   8'h00},
        '{8'hFF,       1'b0, PIN,  2'd1, 8'hFF,      8'h00,   8'h00},
        '{CHAR_SLASH,  1'b0, PIN,  2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_NL,     1'b0, PIN,  2'd2, CHAR_SLASH, CHAR_NL, 8'h00},
        '{CHAR_SLASH,  1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_STAR,   1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_SLASH,  1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_STAR,   1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_NL,     1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_SLASH,  1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_STAR,   1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_SLASH,  1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{8'h0D,       1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_HASH,   1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{8'h78,       1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_NL,     1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_SQUOTE, 1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_BSLASH, 1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_SQUOTE, 1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_DQUOTE, 1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_SQUOTE, 1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_SLASH,  1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_SLASH,  1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_NL,     1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_SLASH,  1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_SEMI,   1'b0, PIN,  2'd1, CHAR_SLASH, 8'h00,   8'h00},
        '{CHAR_SLASH,  1'b1, PIN,  2'd1, END_BYTE,   8'h00,   8'h00},
        '{CHAR_SLASH,  1'b0, PIN,  2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_NL,     1'b1, PIN,  2'd3, CHAR_SLASH, CHAR_NL, END_BYTE},
        '{CHAR_SLASH,  1'b0, PRED, 2'd0, 8'h00,      8'h00,   8'h00},
        '{CHAR_DQUOTE, 1'b1, PRED, 2'd0, 8'h00,      8'h00,   8'h00}
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       s_end_of_input = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_is_end_marker;
    logic       m_last_of_run;

    stim_row_t  pin_row = '0;
    int         src_idle = 0;
    int         sink_stall = 0;
    int         bad_count = 0;

    // predictor state
    logic in_block, star_prev, slash_pend, in_str, str_single, esc_next, drop_line;
    strip_out_t step_out [3];
    int         step_n;
    strip_out_t pending_out [$];

    asm_comment_stripper DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_input  (s_end_of_input),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_is_end_marker (m_is_end_marker),
        .m_last_of_run   (m_last_of_run)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic clear_state();
        in_block = 1'b0;
        star_prev = 1'b0;
        slash_pend = 1'b0;
        in_str = 1'b0;
        str_single = 1'b0;
        esc_next = 1'b0;
        drop_line = 1'b0;
    endtask

    task automatic put_out(input logic [7:0] data, input logic endm);
        if (step_n < 3) begin
            step_out[step_n] = '{data, endm, 1'b0};
            step_n++;
        end
    endtask

    task automatic plain_char(input logic [7:0] c);
        if (c == CHAR_DQUOTE || c == CHAR_SQUOTE) begin
            in_str = 1'b1;
            str_single = (c == CHAR_SQUOTE);
            esc_next = 1'b0;
            put_out(c, 1'b0);
        end else if (c == CHAR_SLASH) begin
            slash_pend = 1'b1;
        end else if (c == CHAR_HASH || c == CHAR_SEMI) begin
            drop_line = 1'b1;
        end else begin
            put_out(c, 1'b0);
        end
    endtask

    task automatic strip_predict(input logic [7:0] c, input logic eoi);
        logic [7:0] close_q;
        step_n = 0;
        close_q = str_single ? CHAR_SQUOTE : CHAR_DQUOTE;
        if (c == CHAR_NL) begin
            if (slash_pend) begin
                put_out(CHAR_SLASH, 1'b0);
                slash_pend = 1'b0;
            end
            put_out(CHAR_NL, 1'b0);
            in_str = 1'b0;
            str_single = 1'b0;
            esc_next = 1'b0;
            drop_line = 1'b0;
            star_prev = 1'b0;
        end else if (in_block) begin
            if (star_prev && c == CHAR_SLASH) begin
                in_block = 1'b0;
                star_prev = 1'b0;
            end else begin
                star_prev = (c == CHAR_STAR);
            end
        end else if (drop_line) begin
            // rest of line dropped
        end else if (in_str) begin
            put_out(c, 1'b0);
            if (esc_next) begin
                esc_next = 1'b0;
            end else if (c == CHAR_BSLASH) begin
                esc_next = 1'b1;
            end else if (c == close_q) begin
                in_str = 1'b0;
                str_single = 1'b0;
            end
        end else if (slash_pend) begin
            slash_pend = 1'b0;
            if (c == CHAR_STAR) begin
                in_block = 1'b1;
                star_prev = 1'b0;
            end else if (c == CHAR_SLASH) begin
                drop_line = 1'b1;
            end else begin
                put_out(CHAR_SLASH, 1'b0);
                plain_char(c);
            end
        end else begin
            plain_char(c);
        end
        if (eoi) begin
            if (slash_pend) begin
                put_out(CHAR_SLASH, 1'b0);
            end
            put_out(END_BYTE, 1'b1);
            clear_state();
        end
        if (step_n > 0) begin
            step_out[step_n - 1].last = 1'b1;
        end
    endtask

    task automatic note_bad(input string what, input strip_out_t want, input strip_out_t got);
        bad_count++;
        if (bad_count <= 10) begin
            $display({"mismatch %0d (%s): want byte=%02h end=%0b last=%0b, ",
                      "got byte=%02h end=%0b last=%0b"},
                     bad_count, what, want.data, want.endm, want.last,
                     got.data, got.endm, got.last);
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall);
    end

    // both sides observed in one place so a request and its results never race
    always @(posedge aclk) begin : watch
        strip_out_t got;
        strip_out_t want;
        logic [7:0] pw [3];
        if (aresetn) begin
            if (s_valid && s_ready) begin
                strip_predict(s_in_byte, s_end_of_input);
                if (pin_row.pinned) begin
                    pw = '{pin_row.w0, pin_row.w1, pin_row.w2};
                    step_n = pin_row.cnt;
                    for (int k = 0; k < step_n; k++) begin
                        step_out[k] = '{pw[k], pin_row.eoi && k == step_n - 1, k == step_n - 1};
                    end
                end
                for (int k = 0; k < step_n; k++) begin
                    pending_out.push_back(step_out[k]);
                end
            end
            if (m_valid && m_ready) begin
                got = '{m_out_byte, m_is_end_marker, m_last_of_run};
                if (pending_out.size() == 0) begin
                    note_bad("unexpected", '0, got);
                end else begin
                    want = pending_out.pop_front();
                    if (got.data !== want.data || got.endm !== want.endm ||
                        got.last !== want.last) begin
                        note_bad("field", want, got);
                    end
                end
            end
        end
    end

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 10) return CHAR_NL;
        if (r < 21) return CHAR_SLASH;
        if (r < 29) return CHAR_STAR;
        if (r < 33) return CHAR_HASH;
        if (r < 37) return CHAR_SEMI;
        if (r < 43) return CHAR_DQUOTE;
        if (r < 49) return CHAR_SQUOTE;
        if (r < 55) return CHAR_BSLASH;
        if (r < 82) return 8'h61 + 8'($urandom_range(25));
        return 8'($urandom_range(255));
    endfunction

    task automatic send_row(input stim_row_t row);
        if (src_idle != 0 && $urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle);
        end
        s_valid <= 1'b1;
        s_in_byte <= row.ch;
        s_end_of_input <= row.eoi;
        pin_row <= row;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_out.size() != 0) @(posedge aclk);
    endtask

    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int src_pct [4];
        int sink_pct [4];
        stim_row_t row;
        src_pct = '{0, 46, 0, 37};
        sink_pct = '{0, 0, 46, 37};
        clear_state();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_DIR; i++) begin
            send_row(DIR_ROWS[i]);
        end
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            src_idle = src_pct[p];
            sink_stall = sink_pct[p];
            for (int i = 0; i < NUM_RAND; i++) begin
                row = '0;
                row.ch = pick_char();
                row.eoi = ($urandom_range(59) == 0);
                send_row(row);
            end
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (bad_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/asm_cs_pkg.sv
rtl/asm_cs_front.sv
rtl/asm_cs_queue.sv
rtl/asm_cs_back.sv
rtl/asm_comment_stripper.sv
rtl/asm_cs_checker.sv
test/asm_comment_stripper_test.sv
